/* sv/gtr_pkg.sv */
// Shared constants, codes and request/result types of the Gouraud triangle rasteriser.
package gtr_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 16;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 8;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by_coord;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [COLOR_W-1:0]         color_a;
    logic [COLOR_W-1:0]         color_b;
    logic [COLOR_W-1:0]         color_c;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               rejected;
  } out_res_t;

endpackage

/* sv/gtr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gtr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gouraud_triangle_rasterizer_unit.sv */
// Top level of the Gouraud triangle rasteriser: sequencer, shared divider and multiplier.
//
//   channel | direction | signals
//   in      | request   | in_valid, in_ready, in_data (in_req_t)
//   out     | result    | out_valid, out_ready, out_data (out_res_t)
//   cfg     | write     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One request at a time. Draw requests are paced by the serial divider and the single shared
// multiplier; a zero-length span skips the divider.
// After reset a clearing pass over all STORE_SIZE entries runs before in_ready rises.
// A pending result waits in the output register; in_ready stays low until it is loaded.
module gouraud_triangle_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtr_pkg::in_req_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtr_pkg::out_res_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gtr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtr_pkg::CFG_W-1:0]         cfg_data
);
  import gtr_pkg::*;

  localparam int T_W    = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(T_W);
  localparam int MA_W   = 14;
  localparam int PROD_W = MA_W + T_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic [COLOR_W-1:0]        ca;
    logic [COLOR_W-1:0]        cb;
  } edge_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_READ, S_RDWAIT, S_SETUP, S_EDGE, S_ROWS, S_WEND,
    S_RCHK, S_RDIVL, S_RDIVS, S_RMUL, S_RACC, S_SPAN, S_PCHK, S_PDIV,
    S_PMUL, S_PACC, S_PWR, S_DONE
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] width_r, height_r;
  logic signed [12:0] ew, eh;

  logic signed [COORD_W-1:0] vx_r [3];
  logic signed [COORD_W-1:0] vy_r [3];
  logic [COLOR_W-1:0]        vc_r [3];

  out_res_t res_r, out_data_r;
  logic     out_valid_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic     clr_reply_r;

  edge_t       edg [3];
  logic [11:0] hgt [3];
  logic [1:0]  best, sidx;
  logic        reject;
  logic [1:0]  best_r;
  logic        sel_r;

  edge_t L_r, S_r;
  logic [11:0] dyl_r, dys_r;
  logic signed [MA_W-1:0] dxl_r, dxs_r;
  logic signed [12:0] y_r, row_hi_r;
  logic [T_W-1:0] tl_r, ts_r, tp_r;
  logic [3:0] k_r;
  logic [1:0] ch_sel;
  logic signed [12:0] xl_r, xsh_r;
  logic [COLOR_W-1:0] cl_r, csh_r;
  logic signed [12:0] x_r, sp_hi_r, sp_xs_r;
  logic [11:0] sp_len_r;
  logic [COLOR_W-1:0] sp_cs_r, sp_ce_r, pix_r;

  logic [12:0] div_rem_r;
  logic [11:0] div_den_r;
  logic [T_W-1:0] div_q_r;
  logic [CNT_W-1:0] div_cnt_r;
  logic div_busy_r;
  logic [13:0] div_sh;
  logic div_ge;
  logic [12:0] div_rem_nxt;

  logic signed [MA_W-1:0] mul_a;
  logic [T_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [COORD_W-1:0] acc_xbase;
  logic [7:0] acc_cbase;
  logic signed [PROD_W-1:0] xsum, xq, csum;
  logic signed [12:0] xres;
  logic [7:0] cres;

  logic signed [12:0] sp_sx, sp_ex;
  logic [COLOR_W-1:0] sp_sc, sp_ec;
  logic signed [13:0] ydiff;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, pix_addr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  function automatic edge_t make_edge(
    input logic signed [COORD_W-1:0] x1, input logic signed [COORD_W-1:0] y1,
    input logic [COLOR_W-1:0] c1,
    input logic signed [COORD_W-1:0] x2, input logic signed [COORD_W-1:0] y2,
    input logic [COLOR_W-1:0] c2);
    edge_t e;
    if (y1 < y2) begin
      e = '{xa: x1, ya: y1, xb: x2, yb: y2, ca: c1, cb: c2};
    end else begin
      e = '{xa: x2, ya: y2, xb: x1, yb: y1, ca: c2, cb: c1};
    end
    return e;
  endfunction

  function automatic logic [11:0] edge_h(input edge_t e);
    logic [12:0] d;
    d = {e.yb[COORD_W-1], e.yb} - {e.ya[COORD_W-1], e.ya};
    return d[11:0];
  endfunction

  function automatic logic signed [MA_W-1:0] edge_dx(input edge_t e);
    return MA_W'(e.xb) - MA_W'(e.xa);
  endfunction

  function automatic logic on_scr(
    input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
    input logic signed [12:0] w, input logic signed [12:0] h);
    logic signed [12:0] xe, ye;
    xe = 13'(x);
    ye = 13'(y);
    return (xe >= 13'sd0) && (xe < w) && (ye >= 13'sd0) && (ye < h);
  endfunction

  function automatic logic [7:0] chan(input logic [COLOR_W-1:0] c, input logic [1:0] i);
    return c[8*i +: 8];
  endfunction

  function automatic logic signed [MA_W-1:0] cdelta(
    input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b, input logic [1:0] i);
    return $signed({{(MA_W-8){1'b0}}, chan(b, i)}) - $signed({{(MA_W-8){1'b0}}, chan(a, i)});
  endfunction

  function automatic logic signed [12:0] eff_dim(input logic [CFG_W-1:0] v, input int lim);
    logic signed [12:0] r;
    if (v == '0) begin
      r = 13'sd1;
    end else if (int'(v) > lim) begin
      r = 13'(lim);
    end else begin
      r = $signed({{(13-CFG_W){1'b0}}, v});
    end
    return r;
  endfunction

  assign ew = eff_dim(width_r, MAX_WIDTH);
  assign eh = eff_dim(height_r, MAX_HEIGHT);

  always_comb begin
    edg[0] = make_edge(vx_r[0], vy_r[0], vc_r[0], vx_r[1], vy_r[1], vc_r[1]);
    edg[1] = make_edge(vx_r[1], vy_r[1], vc_r[1], vx_r[2], vy_r[2], vc_r[2]);
    edg[2] = make_edge(vx_r[2], vy_r[2], vc_r[2], vx_r[0], vy_r[0], vc_r[0]);
    for (int i = 0; i < 3; i++) begin
      hgt[i] = edge_h(edg[i]);
    end
  end

  always_comb begin
    logic [11:0] tall;
    logic [2:0]  s;
    best = 2'd0;
    tall = hgt[0];
    if (hgt[1] > tall) begin
      best = 2'd1;
      tall = hgt[1];
    end
    if (hgt[2] > tall) begin
      best = 2'd2;
    end
    s = 3'(best_r) + 3'd1 + 3'(sel_r);
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    sidx = s[1:0];
    reject = !on_scr(vx_r[0], vy_r[0], ew, eh) && !on_scr(vx_r[1], vy_r[1], ew, eh) &&
             !on_scr(vx_r[2], vy_r[2], ew, eh);
  end

  assign div_sh      = (div_cnt_r == '0) ? {1'b0, div_rem_r} : {div_rem_r, 1'b0};
  assign div_ge      = div_sh >= {2'b00, div_den_r};
  assign div_rem_nxt = div_ge ? 13'(div_sh - {2'b00, div_den_r}) : div_sh[12:0];

  always_comb begin
    if (state_r == S_PMUL || state_r == S_PACC) begin
      ch_sel = k_r[1:0];
    end else if (k_r >= 4'd6) begin
      ch_sel = 2'(k_r - 4'd6);
    end else begin
      ch_sel = 2'(k_r - 4'd2);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PMUL) begin
      mul_a = cdelta(sp_cs_r, sp_ce_r, ch_sel);
      mul_b = tp_r;
    end else if (k_r == 4'd0) begin
      mul_a = dxl_r;
      mul_b = tl_r;
    end else if (k_r == 4'd1) begin
      mul_a = dxs_r;
      mul_b = ts_r;
    end else if (k_r < 4'd6) begin
      mul_a = cdelta(L_r.ca, L_r.cb, ch_sel);
      mul_b = tl_r;
    end else begin
      mul_a = cdelta(S_r.ca, S_r.cb, ch_sel);
      mul_b = ts_r;
    end
  end

  always_comb begin
    acc_xbase = (k_r == 4'd0) ? L_r.xa : S_r.xa;
    if (state_r == S_PACC) begin
      acc_cbase = chan(sp_cs_r, ch_sel);
    end else if (k_r >= 4'd6) begin
      acc_cbase = chan(S_r.ca, ch_sel);
    end else begin
      acc_cbase = chan(L_r.ca, ch_sel);
    end
    xsum = (PROD_W'(acc_xbase) <<< FRAC_BITS) + prod_r;
    xq   = xsum >>> FRAC_BITS;
    if (xsum < 0 && xsum[FRAC_BITS-1:0] != '0) begin
      xq = xq + PROD_W'(1);
    end
    xres = xq[12:0];
    csum = ($signed({{(PROD_W-8){1'b0}}, acc_cbase}) <<< FRAC_BITS) + prod_r;
    cres = csum[FRAC_BITS +: 8];
  end

  always_comb begin
    if (xl_r < xsh_r) begin
      sp_sx = xl_r;
      sp_ex = xsh_r;
      sp_sc = cl_r;
      sp_ec = csh_r;
    end else begin
      sp_sx = xsh_r;
      sp_ex = xl_r;
      sp_sc = csh_r;
      sp_ec = cl_r;
    end
  end

  assign ydiff = 14'(y_r) - 14'(L_r.ya);

  assign pix_addr  = ADDR_W'(32'(y_r[11:0]) * MAX_WIDTH + 32'(x_r[11:0]));
  assign ram_raddr = ADDR_W'(32'(vy_r[0][11:0]) * MAX_WIDTH + 32'(vx_r[0][11:0]));
  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_PWR);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : pix_addr;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : pix_r;

  gtr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_SIZE)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * $signed({1'b0, mul_b});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      div_busy_r  <= 1'b0;
      width_r     <= CFG_W'(64);
      height_r    <= CFG_W'(64);
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_SCREEN_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == REG_SCREEN_HEIGHT) begin
          height_r <= cfg_data;
        end
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (div_busy_r) begin
        div_rem_r <= div_rem_nxt;
        div_q_r   <= {div_q_r[T_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(FRAC_BITS)) begin
          div_busy_r <= 1'b0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            vx_r[0] <= in_data.ax;
            vy_r[0] <= in_data.ay;
            vx_r[1] <= in_data.bx;
            vy_r[1] <= in_data.by_coord;
            vx_r[2] <= in_data.cx;
            vy_r[2] <= in_data.cy;
            vc_r[0] <= in_data.color_a;
            vc_r[1] <= in_data.color_b;
            vc_r[2] <= in_data.color_c;
            res_r   <= '0;
            unique case (in_data.opcode)
              OP_DRAW:  state_r <= S_SETUP;
              OP_READ:  state_r <= S_READ;
              OP_CLEAR: begin
                clr_cnt_r   <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= S_CLEAR;
              end
              OP_NOP:   state_r <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
          if (clr_cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
            state_r <= clr_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_READ: begin
          state_r <= on_scr(vx_r[0], vy_r[0], ew, eh) ? S_RDWAIT : S_DONE;
        end
        S_RDWAIT: begin
          res_r.pixel_value <= ram_rdata;
          state_r           <= S_DONE;
        end
        S_SETUP: begin
          if (reject) begin
            res_r.rejected <= 1'b1;
            state_r        <= S_DONE;
          end else begin
            best_r  <= best;
            sel_r   <= 1'b0;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          L_r      <= edg[best_r];
          S_r      <= edg[sidx];
          dyl_r    <= hgt[best_r];
          dys_r    <= hgt[sidx];
          dxl_r    <= edge_dx(edg[best_r]);
          dxs_r    <= edge_dx(edg[sidx]);
          y_r      <= (edg[sidx].ya < 0) ? 13'sd0 : 13'(edg[sidx].ya);
          row_hi_r <= (13'(edg[sidx].yb) > eh - 13'sd1) ? eh - 13'sd1 : 13'(edg[sidx].yb);
          state_r  <= S_ROWS;
        end
        S_ROWS: begin
          state_r <= (dyl_r == '0 || dys_r == '0) ? S_WEND : S_RCHK;
        end
        S_WEND: begin
          if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_EDGE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RCHK: begin
          if (y_r > row_hi_r) begin
            state_r <= S_WEND;
          end else begin
            div_rem_r  <= {1'b0, ydiff[11:0]};
            div_den_r  <= dyl_r;
            div_q_r    <= '0;
            div_cnt_r  <= '0;
            div_busy_r <= 1'b1;
            state_r    <= S_RDIVL;
          end
        end
        S_RDIVL: begin
          if (!div_busy_r) begin
            tl_r       <= div_q_r;
            div_rem_r  <= {1'b0, 12'(y_r - 13'(S_r.ya))};
            div_den_r  <= dys_r;
            div_q_r    <= '0;
            div_cnt_r  <= '0;
            div_busy_r <= 1'b1;
            state_r    <= S_RDIVS;
          end
        end
        S_RDIVS: begin
          if (!div_busy_r) begin
            ts_r    <= div_q_r;
            k_r     <= 4'd0;
            state_r <= S_RMUL;
          end
        end
        S_RMUL: begin
          state_r <= S_RACC;
        end
        S_RACC: begin
          if (k_r == 4'd0) begin
            xl_r <= xres;
          end else if (k_r == 4'd1) begin
            xsh_r <= xres;
          end else if (k_r < 4'd6) begin
            cl_r[8*ch_sel +: 8] <= cres;
          end else begin
            csh_r[8*ch_sel +: 8] <= cres;
          end
          if (k_r == 4'd9) begin
            state_r <= S_SPAN;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_RMUL;
          end
        end
        S_SPAN: begin
          sp_xs_r  <= sp_sx;
          sp_len_r <= 12'(sp_ex - sp_sx);
          sp_cs_r  <= sp_sc;
          sp_ce_r  <= sp_ec;
          x_r      <= (sp_sx < 0) ? 13'sd0 : sp_sx;
          sp_hi_r  <= (sp_ex > ew - 13'sd1) ? ew - 13'sd1 : sp_ex;
          state_r  <= S_PCHK;
        end
        S_PCHK: begin
          if (x_r > sp_hi_r) begin
            y_r     <= y_r + 13'sd1;
            state_r <= S_RCHK;
          end else if (sp_len_r == '0) begin
            tp_r    <= '0;
            k_r     <= 4'd0;
            state_r <= S_PMUL;
          end else begin
            div_rem_r  <= {1'b0, 12'(x_r - sp_xs_r)};
            div_den_r  <= sp_len_r;
            div_q_r    <= '0;
            div_cnt_r  <= '0;
            div_busy_r <= 1'b1;
            state_r    <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (!div_busy_r) begin
            tp_r    <= div_q_r;
            k_r     <= 4'd0;
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          state_r <= S_PACC;
        end
        S_PACC: begin
          pix_r[8*ch_sel +: 8] <= cres;
          if (k_r == 4'd3) begin
            state_r <= S_PWR;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_PMUL;
          end
        end
        S_PWR: begin
          x_r     <= x_r + 13'sd1;
          state_r <= S_PCHK;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Gouraud triangle rasteriser: random and directed requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gtr_pkg::*;

  localparam int  MODE_NONE = 0, MODE_SEND = 1, MODE_RECV = 2, MODE_BOTH = 3;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam int  CYCLE_LIMIT = 20000000;

  typedef struct {
    longint xa, ya, xb, yb;
    logic [31:0] ca, cb;
  } edge_s;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_req_t  in_data;
  out_res_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  in_req_t  req_q[$];
  out_res_t result_q[$];
  logic [31:0] pix_store [STORE_SIZE];
  logic [6:0]  cols_reg, rows_reg;
  int  mode, mismatches, cycles;
  logic req_taken;

  gouraud_triangle_rasterizer_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint eff_cols();
    return cols_reg == 0 ? 1 : (cols_reg > MAX_WIDTH ? MAX_WIDTH : cols_reg);
  endfunction

  function automatic longint eff_rows();
    return rows_reg == 0 ? 1 : (rows_reg > MAX_HEIGHT ? MAX_HEIGHT : rows_reg);
  endfunction

  function automatic bit visible(longint x, longint y);
    return x >= 0 && x < eff_cols() && y >= 0 && y < eff_rows();
  endfunction

  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint t);
    logic [31:0] r;
    longint ca, cb, v;
    r = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      ca = longint'((a >> sh) & 32'hFF);
      cb = longint'((b >> sh) & 32'hFF);
      v  = (ca * ONE + (cb - ca) * t) / ONE;
      r |= (32'(v) & 32'hFF) << sh;
    end
    return r;
  endfunction

  function automatic edge_s order_edge(longint x1, longint y1, logic [31:0] c1,
                                       longint x2, longint y2, logic [31:0] c2);
    edge_s e;
    if (y1 < y2) begin
      e.xa = x1; e.ya = y1; e.ca = c1; e.xb = x2; e.yb = y2; e.cb = c2;
    end else begin
      e.xa = x2; e.ya = y2; e.ca = c2; e.xb = x1; e.yb = y1; e.cb = c1;
    end
    return e;
  endfunction

  function automatic void paint_span(longint xl, logic [31:0] cl, longint xr,
                                     logic [31:0] cr, longint y);
    longint xs, xe, len, lo, hi, t;
    logic [31:0] cs, ce;
    if (xl < xr) begin
      xs = xl; xe = xr; cs = cl; ce = cr;
    end else begin
      xs = xr; xe = xl; cs = cr; ce = cl;
    end
    len = xe - xs;
    lo = xs < 0 ? 0 : xs;
    hi = xe > eff_cols() - 1 ? eff_cols() - 1 : xe;
    for (longint x = lo; x <= hi; x++) begin
      t = len == 0 ? 0 : ((x - xs) * ONE) / len;
      pix_store[(y * MAX_WIDTH + x) % STORE_SIZE] = blend(cs, ce, t);
    end
  endfunction

  function automatic void walk_pair(edge_s lng, edge_s sht);
    longint dyl, dys, lo, hi, tl, ts, xl, xs;
    dyl = lng.yb - lng.ya;
    dys = sht.yb - sht.ya;
    if (dyl == 0 || dys == 0) return;
    lo = sht.ya < 0 ? 0 : sht.ya;
    hi = sht.yb > eff_rows() - 1 ? eff_rows() - 1 : sht.yb;
    for (longint y = lo; y <= hi; y++) begin
      tl = ((y - lng.ya) * ONE) / dyl;
      ts = ((y - sht.ya) * ONE) / dys;
      xl = (lng.xa * ONE + tl * (lng.xb - lng.xa)) / ONE;
      xs = (sht.xa * ONE + ts * (sht.xb - sht.xa)) / ONE;
      paint_span(xl, blend(lng.ca, lng.cb, tl), xs, blend(sht.ca, sht.cb, ts), y);
    end
  endfunction

  function automatic out_res_t rasterise(in_req_t r);
    out_res_t res;
    edge_s e[3];
    longint ax, ay, bx, by, cx, cy, tall;
    int best;
    ax = longint'($signed(r.ax)); ay = longint'($signed(r.ay));
    bx = longint'($signed(r.bx)); by = longint'($signed(r.by_coord));
    cx = longint'($signed(r.cx)); cy = longint'($signed(r.cy));
    res = '0;
    case (r.opcode)
      OP_DRAW: begin
        if (!visible(ax, ay) && !visible(bx, by) && !visible(cx, cy)) begin
          res.rejected = 1'b1;
        end else begin
          e[0] = order_edge(ax, ay, r.color_a, bx, by, r.color_b);
          e[1] = order_edge(bx, by, r.color_b, cx, cy, r.color_c);
          e[2] = order_edge(cx, cy, r.color_c, ax, ay, r.color_a);
          best = 0;
          tall = e[0].yb - e[0].ya;
          for (int i = 1; i < 3; i++) begin
            if (e[i].yb - e[i].ya > tall) begin
              tall = e[i].yb - e[i].ya;
              best = i;
            end
          end
          walk_pair(e[best], e[(best + 1) % 3]);
          walk_pair(e[best], e[(best + 2) % 3]);
        end
      end
      OP_READ: begin
        if (visible(ax, ay)) res.pixel_value = pix_store[(ay * MAX_WIDTH + ax) % STORE_SIZE];
      end
      OP_CLEAR: begin
        foreach (pix_store[i]) pix_store[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_req_t tri_req(int x0, int y0, int x1, int y1, int x2, int y2);
    in_req_t r;
    r.opcode = OP_DRAW;
    r.ax = COORD_W'(x0); r.ay = COORD_W'(y0); r.bx = COORD_W'(x1);
    r.by_coord = COORD_W'(y1); r.cx = COORD_W'(x2); r.cy = COORD_W'(y2);
    r.color_a = $urandom; r.color_b = $urandom; r.color_c = $urandom;
    return r;
  endfunction

  function automatic in_req_t op_req(opcode_t op, int x, int y);
    in_req_t r;
    logic [7*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(in_req_t)-1:0];
    r.opcode = op;
    r.ax = COORD_W'(x);
    r.ay = COORD_W'(y);
    return r;
  endfunction

  function automatic int near(int lim);
    return $urandom_range(0, lim + 3) - 2;
  endfunction

  function automatic in_req_t random_req(int w, int h);
    in_req_t r;
    int pick, bx0, by0;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r = op_req(OP_READ, near(w), near(h));
      if ($urandom_range(0, 7) == 0) begin
        r.ax = COORD_W'($urandom);
        r.ay = COORD_W'($urandom);
      end
    end else if (pick < 85) begin
      bx0 = $urandom_range(0, w - 1);
      by0 = $urandom_range(0, h - 1);
      r = tri_req(bx0 + $urandom_range(0, 12) - 6, by0 + $urandom_range(0, 12) - 6,
                  bx0 + $urandom_range(0, 12) - 6, by0 + $urandom_range(0, 12) - 6,
                  bx0 + $urandom_range(0, 12) - 6, by0 + $urandom_range(0, 12) - 6);
    end else if (pick < 93) begin
      r = op_req(OP_DRAW, $urandom, $urandom);
      if (w * h > 64) begin
        if (r.ax >= 0 && r.ax < 64) r.ax = ~r.ax;
        if (r.bx >= 0 && r.bx < 64) r.bx = ~r.bx;
        if (r.cx >= 0 && r.cx < 64) r.cx = ~r.cx;
      end
    end else if (pick < 97) begin
      r = op_req(OP_NOP, $urandom, $urandom);
    end else begin
      r = op_req(OP_CLEAR, $urandom, $urandom);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg  <= 7'd64;
      rows_reg  <= 7'd64;
      req_taken <= 1'b0;
      foreach (pix_store[i]) pix_store[i] = '0;
    end else begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        if (out_valid && out_ready) begin
          if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", out_data);
          end else if (result_q[0] !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected pixel %h rejected %b, got pixel %h rejected %b",
                       result_q[0].pixel_value, result_q[0].rejected,
                       out_data.pixel_value, out_data.rejected);
            void'(result_q.pop_front());
          end else begin
            void'(result_q.pop_front());
          end
        end
        if (cfg_valid && cfg_ready) begin
          if (cfg_index == REG_SCREEN_WIDTH) cols_reg <= cfg_data;
          else if (cfg_index == REG_SCREEN_HEIGHT) rows_reg <= cfg_data;
        end
        req_taken <= in_valid && in_ready;
        if (in_valid && in_ready) result_q.push_back(rasterise(in_data));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (req_q.size() != 0 &&
            !((mode == MODE_SEND && $urandom_range(0, 99) < 83) ||
              (mode == MODE_BOTH && $urandom_range(0, 99) < 14))) begin
          in_data  <= req_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !((mode == MODE_RECV && $urandom_range(0, 99) < 83) ||
                     (mode == MODE_BOTH && $urandom_range(0, 99) < 14));
    end
  end

  initial begin
    int pw[8] = '{64, 16, 1, 0, 127, 8, 33, 64};
    int ph[8] = '{64, 16, 1, 127, 0, 5, 20, 64};
    int pm[8] = '{MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH,
                  MODE_NONE, MODE_RECV, MODE_BOTH, MODE_SEND};
    int pn[8] = '{60, 80, 60, 60, 60, 80, 90, 90};
    int w, h;
    rst_n = 0; in_valid = 0; out_ready = 0; cfg_valid = 0;
    in_data = '0; cfg_index = '0; cfg_data = '0;
    mode = MODE_NONE; mismatches = 0; cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      repeat (20) @(posedge clk);
      mode = pm[p];
      write_reg(REG_SCREEN_WIDTH, CFG_W'(pw[p]));
      write_reg(REG_SCREEN_HEIGHT, CFG_W'(ph[p]));
      if (p == 7) write_reg(CFG_IDX_W'(2), 7'd3);
      w = pw[p] == 0 ? 1 : (pw[p] > 64 ? 64 : pw[p]);
      h = ph[p] == 0 ? 1 : (ph[p] > 64 ? 64 : ph[p]);
      if (p == 0) begin
        req_q.push_back(op_req(OP_READ, 0, 0));
        req_q.push_back(tri_req(-10, -10, 80, 20, 10, 90));
        req_q.push_back(op_req(OP_READ, 0, 0));
        req_q.push_back(op_req(OP_READ, 63, 63));
        req_q.push_back(op_req(OP_READ, 63, 0));
        req_q.push_back(op_req(OP_READ, -1, 0));
        req_q.push_back(op_req(OP_READ, 64, 5));
        req_q.push_back(op_req(OP_READ, 5, 64));
        req_q.push_back(tri_req(2, 2, 9, 2, 5, 8));
        req_q.push_back(tri_req(20, 3, 20, 9, 20, 12));
        req_q.push_back(tri_req(30, 30, 30, 30, 30, 30));
        req_q.push_back(tri_req(40, 5, 44, 5, 48, 5));
        req_q.push_back(op_req(OP_READ, 20, 5));
        req_q.push_back(tri_req(-2048, -2048, 2047, 2047, -2048, 2047));
        req_q.push_back(tri_req(64, 0, 0, 64, -1, -1));
        req_q.push_back(op_req(OP_NOP, 3, 3));
        req_q.push_back(op_req(OP_READ, 5, 3));
        req_q.push_back(op_req(OP_CLEAR, 0, 0));
        req_q.push_back(op_req(OP_READ, 5, 3));
        req_q.push_back(tri_req(60, 60, 50, 55, 70, 50));
        req_q.push_back(op_req(OP_READ, 2047, -2048));
      end
      if (p == 2) begin
        req_q.push_back(tri_req(-2048, 2047, 2047, -2048, 0, 0));
        req_q.push_back(op_req(OP_READ, 0, 0));
      end
      for (int i = 0; i < pn[p]; i++) req_q.push_back(random_req(w, h));
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
